### design/dnsae_pkg.sv
package dnsae_pkg;

  // message size limit and derived position counter width
  localparam int unsigned MaxMessageBytes = 65536;
  localparam int unsigned MsgPosW = $clog2(MaxMessageBytes + 1);

  // message layout
  localparam logic [3:0] HeaderLast = 4'd11;  // index of final header byte
  localparam logic [3:0] AncountHi  = 4'd6;
  localparam logic [3:0] AncountLo  = 4'd7;
  localparam logic [3:0] QtailLast  = 4'd3;   // index of final qtype/qclass byte
  localparam logic [3:0] FixedLast  = 4'd9;   // index of final fixed-part byte
  localparam logic [3:0] TypeHi     = 4'd0;
  localparam logic [3:0] TypeLo     = 4'd1;
  localparam logic [3:0] RdlenHi    = 4'd8;
  localparam logic [3:0] RdlenLo    = 4'd9;

  localparam logic [7:0]  PtrMin    = 8'd192;
  localparam logic [15:0] AddrBytes = 16'd4;

  localparam logic [15:0] MatchTypeReset = 16'd1;

  // result kinds
  localparam logic KindAddress = 1'b0;
  localparam logic KindStatus  = 1'b1;

  // status codes
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusNoAnswers = 2'd1;
  localparam logic [1:0] StatusNoRecord  = 2'd2;

endpackage

### design/dns_response_a_record_extract_core.sv
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+---------------------------------------------
// in        | input     | in_valid / in_ready   | in_data_byte, in_end_of_message
// out       | output    | out_valid / out_ready | out_result_kind, out_ipv4_address,
//           |           |                       | out_status, out_last
// cfg       | input     | cfg_wr_en (no wait)   | cfg_wr_data (match type)
//
// one byte per cycle when the result register can drain: the parse state updates
// in the accepting cycle and the byte's results (address and/or end status) land
// in the result register the next cycle. a byte giving two results holds the result
// register for two out transactions, so input stalls then.
// reset (rst_n low, synchronous) clears parse state, result register, and
// restores match type to 1. in_ready drops while the result register cannot
// empty in the current cycle.
module dns_response_a_record_extract_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [31:0] out_ipv4_address,
  output logic [1:0]  out_status,
  output logic        out_last
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_QNAME,
    PH_QPTR,
    PH_QTAIL,
    PH_RNAME,
    PH_RPTR,
    PH_RFIXED,
    PH_RDATA
  } phase_t;

  // configuration
  logic [15:0] match_type_r;

  // parse state
  phase_t                          phase_r, phase_nxt;
  logic [3:0]                      byte_cnt_r, byte_cnt_nxt;
  logic [15:0]                     ancount_r, ancount_nxt;
  logic [7:0]                      label_left_r, label_left_nxt;
  logic [15:0]                     rtype_r, rtype_nxt;
  logic [15:0]                     rdlen_r, rdlen_nxt;
  logic [15:0]                     data_left_r, data_left_nxt;
  logic [31:0]                     addr_shift_r, addr_shift_nxt;
  logic                            any_found_r, any_found_nxt;
  logic [dnsae_pkg::MsgPosW-1:0]   msg_pos_r, msg_pos_nxt;

  // result register: pending address and pending status
  logic        have_addr_r, have_addr_nxt;
  logic        have_stat_r, have_stat_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [1:0]  stat_r, stat_nxt;

  logic in_fire, out_fire;
  logic addr_due;
  logic [15:0] data_dec;

  assign out_valid = have_addr_r | have_stat_r;
  // take a byte when the result register is empty or drains fully this cycle
  assign in_ready  = !out_valid || (out_ready && !(have_addr_r && have_stat_r));
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // address result goes first, status follows it
  assign out_result_kind  = have_addr_r ? dnsae_pkg::KindAddress : dnsae_pkg::KindStatus;
  assign out_ipv4_address = have_addr_r ? addr_r : 32'd0;
  assign out_status       = have_addr_r ? dnsae_pkg::StatusOk : stat_r;
  assign out_last         = !(have_addr_r && have_stat_r);

  assign data_dec = data_left_r - 16'd1;

  // one byte of parse work
  always_comb begin
    phase_nxt      = phase_r;
    byte_cnt_nxt   = byte_cnt_r;
    ancount_nxt    = ancount_r;
    label_left_nxt = label_left_r;
    rtype_nxt      = rtype_r;
    rdlen_nxt      = rdlen_r;
    data_left_nxt  = data_left_r;
    addr_shift_nxt = addr_shift_r;
    msg_pos_nxt    = msg_pos_r;
    addr_due       = 1'b0;

    // bytes past the size limit are dropped
    if (msg_pos_r < dnsae_pkg::MsgPosW'(dnsae_pkg::MaxMessageBytes)) begin
      msg_pos_nxt = msg_pos_r + dnsae_pkg::MsgPosW'(1);
      unique case (phase_r)
        PH_HEADER: begin
          if (byte_cnt_r == dnsae_pkg::AncountHi) ancount_nxt[15:8] = in_data_byte;
          if (byte_cnt_r == dnsae_pkg::AncountLo) ancount_nxt[7:0]  = in_data_byte;
          byte_cnt_nxt = byte_cnt_r + 4'd1;
          if (byte_cnt_r == dnsae_pkg::HeaderLast) begin
            byte_cnt_nxt   = '0;
            label_left_nxt = '0;
            phase_nxt      = PH_QNAME;
          end
        end
        PH_QNAME, PH_RNAME: begin
          // label skip, root label, pointer, or new label length
          if (label_left_r != 8'd0) begin
            label_left_nxt = label_left_r - 8'd1;
          end else if (in_data_byte == 8'd0) begin
            byte_cnt_nxt = '0;
            phase_nxt    = (phase_r == PH_QNAME) ? PH_QTAIL : PH_RFIXED;
          end else if (in_data_byte >= dnsae_pkg::PtrMin) begin
            phase_nxt = (phase_r == PH_QNAME) ? PH_QPTR : PH_RPTR;
          end else begin
            label_left_nxt = in_data_byte;
          end
        end
        PH_QPTR: begin
          byte_cnt_nxt = '0;
          phase_nxt    = PH_QTAIL;
        end
        PH_QTAIL: begin
          byte_cnt_nxt = byte_cnt_r + 4'd1;
          if (byte_cnt_r == dnsae_pkg::QtailLast) begin
            byte_cnt_nxt   = '0;
            label_left_nxt = '0;
            phase_nxt      = PH_RNAME;
          end
        end
        PH_RPTR: begin
          byte_cnt_nxt = '0;
          phase_nxt    = PH_RFIXED;
        end
        PH_RFIXED: begin
          if (byte_cnt_r == dnsae_pkg::TypeHi)  rtype_nxt[15:8] = in_data_byte;
          if (byte_cnt_r == dnsae_pkg::TypeLo)  rtype_nxt[7:0]  = in_data_byte;
          if (byte_cnt_r == dnsae_pkg::RdlenHi) rdlen_nxt[15:8] = in_data_byte;
          if (byte_cnt_r == dnsae_pkg::RdlenLo) rdlen_nxt[7:0]  = in_data_byte;
          byte_cnt_nxt = byte_cnt_r + 4'd1;
          if (byte_cnt_r == dnsae_pkg::FixedLast) begin
            byte_cnt_nxt   = '0;
            data_left_nxt  = rdlen_nxt;
            addr_shift_nxt = '0;
            label_left_nxt = '0;
            // zero-length rdata goes straight to the next record
            phase_nxt      = (rdlen_nxt == 16'd0) ? PH_RNAME : PH_RDATA;
          end
        end
        PH_RDATA: begin
          addr_shift_nxt = {addr_shift_r[23:0], in_data_byte};
          data_left_nxt  = data_dec;
          if (data_dec == 16'd0) begin
            label_left_nxt = '0;
            phase_nxt      = PH_RNAME;
            addr_due = (rtype_r == match_type_r) && (rdlen_r == dnsae_pkg::AddrBytes) &&
                       (ancount_r != 16'd0);
          end
        end
        default: ;
      endcase
    end

    any_found_nxt = any_found_r | addr_due;
  end

  // result register next values
  always_comb begin
    have_addr_nxt = have_addr_r;
    have_stat_nxt = have_stat_r;
    addr_nxt      = addr_r;
    stat_nxt      = stat_r;
    if (out_fire) begin
      if (have_addr_r) have_addr_nxt = 1'b0;
      else             have_stat_nxt = 1'b0;
    end
    if (in_fire) begin
      have_addr_nxt = addr_due;
      have_stat_nxt = in_end_of_message;
      addr_nxt      = addr_shift_nxt;
      // answer count is final by the end byte; any_found includes this byte
      if (ancount_nxt == 16'd0)  stat_nxt = dnsae_pkg::StatusNoAnswers;
      else if (any_found_nxt)    stat_nxt = dnsae_pkg::StatusOk;
      else                       stat_nxt = dnsae_pkg::StatusNoRecord;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_type_r <= dnsae_pkg::MatchTypeReset;
      phase_r      <= PH_HEADER;
      byte_cnt_r   <= '0;
      ancount_r    <= '0;
      label_left_r <= '0;
      rtype_r      <= '0;
      rdlen_r      <= '0;
      data_left_r  <= '0;
      addr_shift_r <= '0;
      any_found_r  <= 1'b0;
      msg_pos_r    <= '0;
      have_addr_r  <= 1'b0;
      have_stat_r  <= 1'b0;
      addr_r       <= '0;
      stat_r       <= '0;
    end else begin
      if (cfg_wr_en) match_type_r <= cfg_wr_data;
      have_addr_r <= have_addr_nxt;
      have_stat_r <= have_stat_nxt;
      addr_r      <= addr_nxt;
      stat_r      <= stat_nxt;
      if (in_fire) begin
        if (in_end_of_message) begin
          // message done: back to the start of a new one
          phase_r      <= PH_HEADER;
          byte_cnt_r   <= '0;
          ancount_r    <= '0;
          label_left_r <= '0;
          rtype_r      <= '0;
          rdlen_r      <= '0;
          data_left_r  <= '0;
          addr_shift_r <= '0;
          any_found_r  <= 1'b0;
          msg_pos_r    <= '0;
        end else begin
          phase_r      <= phase_nxt;
          byte_cnt_r   <= byte_cnt_nxt;
          ancount_r    <= ancount_nxt;
          label_left_r <= label_left_nxt;
          rtype_r      <= rtype_nxt;
          rdlen_r      <= rdlen_nxt;
          data_left_r  <= data_left_nxt;
          addr_shift_r <= addr_shift_nxt;
          any_found_r  <= any_found_nxt;
          msg_pos_r    <= msg_pos_nxt;
        end
      end
    end
  end

endmodule
